// ----- design/sdfr_pkg.sv -----
// types and constants shared by the frame receiver modules
`default_nettype none
package sdfr_pkg;

	localparam int BYTE_W    = 8;
	localparam int CFG_IDX_W = 3;

	localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'h0D;
	localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h0A;
	localparam logic [BYTE_W-1:0] ABORT_BYTE_RST  = 8'hEF;
	localparam logic [BYTE_W-1:0] END_BYTE_RST    = 8'h0D;
	localparam logic [BYTE_W-1:0] FLAG_VALUE_RST  = 8'h01;

	localparam int ALERT_BASE_IDX = 3;
	localparam int ALERT_OFFSET   = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SYNC_FIRST  = 3'd0,
		REG_SYNC_SECOND = 3'd1,
		REG_ABORT_BYTE  = 3'd2,
		REG_END_BYTE    = 3'd3,
		REG_FLAG_VALUE  = 3'd4
	} cfg_reg_t;

	typedef enum logic [3:0] {
		PH_HUNT  = 4'b0001,
		PH_SYNC2 = 4'b0010,
		PH_FIRST = 4'b0100,
		PH_STORE = 4'b1000
	} phase_t;

	typedef enum logic [5:0] {
		ST_IDLE    = 6'b000001,
		ST_RD_BASE = 6'b000010,
		ST_RD_IDX  = 6'b000100,
		ST_CHECK   = 6'b001000,
		ST_EMIT_RD = 6'b010000,
		ST_EMIT_LD = 6'b100000
	} seq_state_t;

	typedef struct packed {
		logic [BYTE_W-1:0] sync_first;
		logic [BYTE_W-1:0] sync_second;
		logic [BYTE_W-1:0] abort_byte;
		logic [BYTE_W-1:0] end_byte;
		logic [BYTE_W-1:0] flag_value;
	} cfg_t;

endpackage
`default_nettype wire

// ----- design/sdfr_store.sv -----
// frame byte store: one write port, one registered read port, per-entry valid bits
`default_nettype none
module sdfr_store import sdfr_pkg::*; #(
	parameter int DEPTH = 40,
	parameter int AW    = 6
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire logic [AW-1:0]     wr_addr,
	input  wire logic [BYTE_W-1:0] wr_data,
	input  wire logic              rd_en,
	input  wire logic [AW-1:0]     rd_addr,
	output logic      [BYTE_W-1:0] rd_data
);

	logic [BYTE_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]  vld_q;
	logic [BYTE_W-1:0] rd_data_q;
	logic              rd_hit_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_hit_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_hit_q <= vld_q[rd_addr];
			end
		end
	end

	// unwritten entries read as zero
	assign rd_data = rd_hit_q ? rd_data_q : '0;

endmodule
`default_nettype wire

// ----- design/sync_delimited_frame_receiver.sv -----
// frame receiver top level: sync hunt, store control and frame-end readout sequencer
// a byte that does not end a frame keeps the input ready; an end byte holds it off
// for the alert check (base read, index read, compare), then a store read and load
//   per result (load only for an empty frame) as the output side takes them; ready after the last load
// one store read port serves the alert check and the readout, one read per cycle
// async reset restores register defaults, hunting phase, clear alert; no clearing pass
`default_nettype none
module sync_delimited_frame_receiver import sdfr_pkg::*; #(
	parameter int FRAME_LIMIT = 40
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_write,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [BYTE_W-1:0]    cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [BYTE_W-1:0]    rx_byte,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic      [BYTE_W-1:0]    payload_byte,
	output logic                      byte_valid,
	output logic                      last_of_frame,
	output logic                      alert_sticky
);

	localparam int AW = $clog2(FRAME_LIMIT);
	localparam logic [AW-1:0] LAST_IDX  = AW'(FRAME_LIMIT - 1);
	localparam logic [AW-1:0] BASE_ADDR = AW'(ALERT_BASE_IDX);
	localparam int IDX_W = BYTE_W + 1;

	cfg_t              cfg_q;
	phase_t            phase_q;
	seq_state_t        state_q;
	logic [AW-1:0]     fill_q;
	logic [AW-1:0]     count_q;
	logic [AW-1:0]     emit_idx_q;
	logic              in_range_q;
	logic              alert_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_bvalid_q;
	logic              out_last_q;
	logic              out_alert_q;

	logic              accept;
	logic              wr_en;
	logic [AW-1:0]     fill_next;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic [BYTE_W-1:0] rd_data;
	logic [IDX_W-1:0]  alert_idx;
	logic              idx_in_range;
	logic              empty_frame;
	logic              emit_last;
	logic              out_free;
	logic              out_load;

	assign in_ready     = (state_q == ST_IDLE);
	assign accept       = in_valid && in_ready;
	assign fill_next    = (fill_q == LAST_IDX) ? '0 : fill_q + 1'b1;
	assign alert_idx    = {1'b0, rd_data} + IDX_W'(ALERT_OFFSET);
	assign idx_in_range = (alert_idx < IDX_W'(FRAME_LIMIT));
	assign empty_frame  = (count_q == '0);
	assign emit_last    = empty_frame || (emit_idx_q == count_q - 1'b1);
	assign out_free     = !out_valid_q || out_ready;
	assign out_load     = (state_q == ST_EMIT_LD) && out_free;

	assign wr_en = accept && ((phase_q == PH_STORE) ||
		((phase_q == PH_FIRST) && (rx_byte != cfg_q.abort_byte)));

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = BASE_ADDR;
		unique case (state_q)
			ST_RD_BASE: begin
				rd_en = 1'b1;
			end
			ST_RD_IDX: begin
				rd_en   = 1'b1;
				rd_addr = idx_in_range ? alert_idx[AW-1:0] : '0;
			end
			ST_EMIT_RD: begin
				rd_en   = 1'b1;
				rd_addr = emit_idx_q;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	sdfr_store #(
		.DEPTH (FRAME_LIMIT),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (fill_q),
		.wr_data (rx_byte),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_first  <= SYNC_FIRST_RST;
			cfg_q.sync_second <= SYNC_SECOND_RST;
			cfg_q.abort_byte  <= ABORT_BYTE_RST;
			cfg_q.end_byte    <= END_BYTE_RST;
			cfg_q.flag_value  <= FLAG_VALUE_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_SYNC_FIRST:  cfg_q.sync_first  <= cfg_data;
				REG_SYNC_SECOND: cfg_q.sync_second <= cfg_data;
				REG_ABORT_BYTE:  cfg_q.abort_byte  <= cfg_data;
				REG_END_BYTE:    cfg_q.end_byte    <= cfg_data;
				REG_FLAG_VALUE:  cfg_q.flag_value  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			count_q     <= '0;
			emit_idx_q  <= '0;
			in_range_q  <= 1'b0;
			alert_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (phase_q)
							PH_HUNT: begin
								if (rx_byte == cfg_q.sync_first) begin
									phase_q <= PH_SYNC2;
								end
							end
							PH_SYNC2: begin
								phase_q <= (rx_byte == cfg_q.sync_second) ? PH_FIRST : PH_HUNT;
							end
							PH_FIRST: begin
								if (rx_byte == cfg_q.abort_byte) begin
									phase_q <= PH_HUNT;
								end else begin
									phase_q <= PH_STORE;
									fill_q  <= fill_next;
								end
							end
							PH_STORE: begin
								if (rx_byte == cfg_q.end_byte) begin
									phase_q <= PH_HUNT;
									count_q <= fill_q;
									fill_q  <= '0;
									state_q <= ST_RD_BASE;
								end else begin
									fill_q <= fill_next;
								end
							end
							default: phase_q <= PH_HUNT;
						endcase
					end
				end
				ST_RD_BASE: begin
					state_q <= ST_RD_IDX;
				end
				ST_RD_IDX: begin
					in_range_q <= idx_in_range;
					state_q    <= ST_CHECK;
				end
				ST_CHECK: begin
					if (in_range_q && (rd_data == cfg_q.flag_value)) begin
						alert_q <= 1'b1;
					end
					emit_idx_q <= '0;
					state_q    <= empty_frame ? ST_EMIT_LD : ST_EMIT_RD;
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_LD;
				end
				ST_EMIT_LD: begin
					if (out_free) begin
						if (emit_last) begin
							state_q <= ST_IDLE;
						end else begin
							emit_idx_q <= emit_idx_q + 1'b1;
							state_q    <= ST_EMIT_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_byte_q   <= empty_frame ? '0 : rd_data;
			out_bvalid_q <= !empty_frame;
			out_last_q   <= emit_last;
			out_alert_q  <= alert_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign payload_byte  = out_byte_q;
	assign byte_valid    = out_bvalid_q;
	assign last_of_frame = out_last_q;
	assign alert_sticky  = out_alert_q;

endmodule
`default_nettype wire

// ----- tb/frame_rx_checker.sv -----
// frame receiver checker: tracks register writes and requests, predicts each frame readout
module frame_rx_checker import sdfr_pkg::*; #(
	parameter int FRAME_LIMIT = 40
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_write,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [BYTE_W-1:0]    cfg_data,
	input  wire logic                 in_valid,
	input  wire logic                 in_ready,
	input  wire logic [BYTE_W-1:0]    rx_byte,
	input  wire logic                 out_valid,
	input  wire logic                 out_ready,
	input  wire logic [BYTE_W-1:0]    payload_byte,
	input  wire logic                 byte_valid,
	input  wire logic                 last_of_frame,
	input  wire logic                 alert_sticky,
	output int                        mismatches,
	output int                        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              data_ok;
		logic              last;
		logic              alert;
	} rx_result_t;

	cfg_t              regs;
	phase_t            rx_phase;
	logic [5:0]        fill;
	logic [BYTE_W-1:0] store [FRAME_LIMIT];
	logic              alert_flag;
	rx_result_t        readout_q [$];
	int                errors = 0;

	assign mismatches = errors;

	task automatic note_mismatch(input string what);
		errors++;
		if (errors <= 40)
			$display("%0t ns mismatch: %s", $time, what);
	endtask

	task automatic clear_frame_state();
		regs = '{SYNC_FIRST_RST, SYNC_SECOND_RST, ABORT_BYTE_RST, END_BYTE_RST, FLAG_VALUE_RST};
		rx_phase = PH_HUNT;
		fill = '0;
		foreach (store[i])
			store[i] = '0;
		alert_flag = 1'b0;
		readout_q.delete();
	endtask

	task automatic keep_byte(input logic [BYTE_W-1:0] b);
		if (fill < FRAME_LIMIT)
			store[fill] = b;
		fill = fill + 1'b1;
	endtask

	task automatic close_frame();
		int count;
		int idx;
		rx_result_t r;
		count = (fill > 0) ? int'(fill) - 1 : 0;
		idx = int'(store[ALERT_BASE_IDX]) + ALERT_OFFSET;
		if (idx < FRAME_LIMIT) begin
			if (store[idx] == regs.flag_value)
				alert_flag = 1'b1;
		end
		if (count == 0) begin
			r.data = '0;
			r.data_ok = 1'b0;
			r.last = 1'b1;
			r.alert = alert_flag;
			readout_q.push_back(r);
		end else begin
			for (int i = 0; i < count; i++) begin
				r.data = store[i];
				r.data_ok = 1'b1;
				r.last = (i == count - 1);
				r.alert = alert_flag;
				readout_q.push_back(r);
			end
		end
		rx_phase = PH_HUNT;
		fill = '0;
	endtask

	task automatic take_byte(input logic [BYTE_W-1:0] b);
		case (rx_phase)
			PH_HUNT: begin
				if (b == regs.sync_first)
					rx_phase = PH_SYNC2;
			end
			PH_SYNC2: begin
				rx_phase = (b == regs.sync_second) ? PH_FIRST : PH_HUNT;
			end
			PH_FIRST: begin
				if (b == regs.abort_byte) begin
					rx_phase = PH_HUNT;
				end else begin
					rx_phase = PH_STORE;
					keep_byte(b);
					if (fill >= FRAME_LIMIT)
						fill = '0;
				end
			end
			default: begin
				keep_byte(b);
				if (b == regs.end_byte)
					close_frame();
				if (fill >= FRAME_LIMIT)
					fill = '0;
			end
		endcase
	endtask

	task automatic write_reg();
		case (cfg_index)
			REG_SYNC_FIRST:  regs.sync_first = cfg_data;
			REG_SYNC_SECOND: regs.sync_second = cfg_data;
			REG_ABORT_BYTE:  regs.abort_byte = cfg_data;
			REG_END_BYTE:    regs.end_byte = cfg_data;
			REG_FLAG_VALUE:  regs.flag_value = cfg_data;
			default: ;
		endcase
	endtask

	task automatic check_result();
		rx_result_t want;
		if (readout_q.size() == 0) begin
			note_mismatch($sformatf("result with nothing expected, payload_byte %h", payload_byte));
		end else begin
			want = readout_q.pop_front();
			if (payload_byte !== want.data)
				note_mismatch($sformatf("payload_byte %h, expected %h", payload_byte, want.data));
			if (byte_valid !== want.data_ok)
				note_mismatch($sformatf("byte_valid %b, expected %b", byte_valid, want.data_ok));
			if (last_of_frame !== want.last)
				note_mismatch($sformatf("last_of_frame %b, expected %b", last_of_frame, want.last));
			if (alert_sticky !== want.alert)
				note_mismatch($sformatf("alert_sticky %b, expected %b", alert_sticky, want.alert));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_frame_state();
			pending <= 0;
		end else begin
			if (out_valid && out_ready)
				check_result();
			if (in_valid && in_ready)
				take_byte(rx_byte);
			if (cfg_write)
				write_reg();
			pending <= readout_q.size();
		end
	end

endmodule

// ----- tb/tb_top.sv -----
// frame receiver testbench top: clock, reset, register setup, byte requests and verdict
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import sdfr_pkg::*;

	localparam int FRAME_LIMIT     = 40;
	localparam int IDLE_LIMIT      = 2000;
	localparam int HOLD_CYCLES     = 300;
	localparam int SETTLE_CYCLES   = 16;
	localparam int ITEMS_PER_PHASE = 6;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [BYTE_W-1:0]    cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [BYTE_W-1:0]    rx_byte;
	logic                 out_valid;
	logic                 out_ready;
	logic [BYTE_W-1:0]    payload_byte;
	logic                 byte_valid;
	logic                 last_of_frame;
	logic                 alert_sticky;
	int                   mismatches;
	int                   pending;

	cfg_t cur_cfg;
	int   items_sent = 0;
	int   tx_idle_pct = 0;
	int   rx_stall_pct = 0;
	int   hold_req = 0;
	int   holds_done = 0;
	int   quiet_cycles = 0;

	sync_delimited_frame_receiver #(.FRAME_LIMIT(FRAME_LIMIT)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.payload_byte(payload_byte),
		.byte_valid(byte_valid),
		.last_of_frame(last_of_frame),
		.alert_sticky(alert_sticky)
	);

	frame_rx_checker #(.FRAME_LIMIT(FRAME_LIMIT)) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.payload_byte(payload_byte),
		.byte_valid(byte_valid),
		.last_of_frame(last_of_frame),
		.alert_sticky(alert_sticky),
		.mismatches(mismatches),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// output side: random stalls, plus long hold-offs on request
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != holds_done) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				holds_done++;
			end
			out_ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	function automatic logic [BYTE_W-1:0] byte_other_than(input logic [BYTE_W-1:0] v);
		logic [BYTE_W-1:0] b;
		do
			b = BYTE_W'($urandom);
		while (b == v);
		return b;
	endfunction

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do
			@(posedge clk);
		while (!in_ready);
		items_sent++;
	endtask

	// sync pair, payload of len bytes, then the end byte
	task automatic send_frame(input int len);
		logic [BYTE_W-1:0] lead;
		lead = byte_other_than(cur_cfg.abort_byte);
		if ($urandom_range(7) == 0 && cur_cfg.end_byte != cur_cfg.abort_byte)
			lead = cur_cfg.end_byte;
		send_byte(cur_cfg.sync_first);
		send_byte(cur_cfg.sync_second);
		send_byte(lead);
		for (int i = 1; i < len; i++)
			send_byte(byte_other_than(cur_cfg.end_byte));
		send_byte(cur_cfg.end_byte);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_regs(input cfg_t c);
		cfg_write <= 1'b1;
		cfg_index <= REG_SYNC_FIRST;
		cfg_data <= c.sync_first;
		@(posedge clk);
		cfg_index <= REG_SYNC_SECOND;
		cfg_data <= c.sync_second;
		@(posedge clk);
		cfg_index <= REG_ABORT_BYTE;
		cfg_data <= c.abort_byte;
		@(posedge clk);
		cfg_index <= REG_END_BYTE;
		cfg_data <= c.end_byte;
		@(posedge clk);
		cfg_index <= REG_FLAG_VALUE;
		cfg_data <= c.flag_value;
		@(posedge clk);
		// unmapped index, must be ignored
		cfg_index <= CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, REG_FLAG_VALUE + 1));
		cfg_data <= BYTE_W'($urandom);
		@(posedge clk);
		cfg_write <= 1'b0;
		cur_cfg = c;
	endtask

	task automatic run_random(input int n);
		int stop_at;
		int pick;
		stop_at = items_sent + n;
		while (items_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				if ($urandom_range(9) == 0)
					send_frame($urandom_range(FRAME_LIMIT + 5, FRAME_LIMIT - 4));
				else
					send_frame($urandom_range(12, 1));
			end else if (pick < 85) begin
				repeat ($urandom_range(4, 1)) send_byte(BYTE_W'($urandom));
			end else if (pick < 93) begin
				send_byte(cur_cfg.sync_first);
				send_byte(byte_other_than(cur_cfg.sync_second));
			end else begin
				send_byte(cur_cfg.sync_first);
				send_byte(cur_cfg.sync_second);
				send_byte(cur_cfg.abort_byte);
			end
		end
	endtask

	initial begin
		logic [BYTE_W-1:0] opening [27];
		cfg_t next_cfg;
		cfg_t reset_cfg;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		rx_byte = '0;
		reset_cfg = '{SYNC_FIRST_RST, SYNC_SECOND_RST, ABORT_BYTE_RST, END_BYTE_RST,
			FLAG_VALUE_RST};
		cur_cfg = reset_cfg;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// second sync miss, abort, end byte as first payload, out-of-range and hitting alert index
		opening = '{SYNC_FIRST_RST, SYNC_FIRST_RST, SYNC_SECOND_RST,
			SYNC_FIRST_RST, SYNC_SECOND_RST, ABORT_BYTE_RST,
			SYNC_FIRST_RST, SYNC_SECOND_RST, END_BYTE_RST, 8'h55, END_BYTE_RST,
			SYNC_FIRST_RST, SYNC_SECOND_RST, 8'h00, 8'h02, 8'h03, 8'hFF, END_BYTE_RST,
			SYNC_FIRST_RST, SYNC_SECOND_RST, 8'h11, 8'h22, 8'h33, 8'h01, 8'hAA,
			FLAG_VALUE_RST, END_BYTE_RST};
		foreach (opening[i])
			send_byte(opening[i]);

		for (int p = 0; p < 4; p++) begin
			if (p > 0) begin
				drain();
				case (p)
					1: next_cfg = '0;
					2: next_cfg = '1;
					default: begin
						next_cfg.sync_first = BYTE_W'($urandom);
						next_cfg.sync_second = BYTE_W'($urandom);
						next_cfg.abort_byte = BYTE_W'($urandom);
						next_cfg.end_byte = BYTE_W'($urandom);
						next_cfg.flag_value = BYTE_W'($urandom);
					end
				endcase
				write_regs(next_cfg);
			end
			case (p)
				1: begin
					tx_idle_pct = 48;
					rx_stall_pct <= 0;
				end
				2: begin
					tx_idle_pct = 0;
					rx_stall_pct <= 48;
				end
				3: begin
					tx_idle_pct = 17;
					rx_stall_pct <= 17;
				end
				default: begin
					tx_idle_pct = 0;
					rx_stall_pct <= 0;
				end
			endcase
			// full store and wrapped empty frame
			if (p == 0)
				send_frame(FRAME_LIMIT);
			run_random(ITEMS_PER_PHASE);
		end

		// output held off while frames keep coming
		drain();
		write_regs(reset_cfg);
		tx_idle_pct = 0;
		rx_stall_pct <= 0;
		hold_req <= hold_req + 1;
		send_frame(8);
		send_frame(5);
		send_frame(3);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
